// File: rtl/fstp_pkg.sv
// Package of the fair-share task picker: beat and slot types, state codes,
// operation codes, controller states and the weight and tick tables.
// Depends on nothing; fstp_if and the top module import it, fstp_div does not.
package fstp_pkg;

  localparam int NUM_SLOTS_DEF = 64;
  localparam int WEIGHT_W      = 17;
  localparam int TICK_W        = 17;
  localparam int SLICE_W       = 14;
  localparam int NUM_W         = SLICE_W + WEIGHT_W;

  localparam logic [2:0] ST_UNUSED   = 3'd0;
  localparam logic [2:0] ST_SLEEPING = 3'd2;
  localparam logic [2:0] ST_RUNNABLE = 3'd3;
  localparam logic [2:0] ST_RUNNING  = 3'd4;
  localparam logic [2:0] ST_LAST     = 3'd5;

  localparam logic [5:0] MAX_NICE   = 6'd39;
  localparam logic [5:0] RESET_NICE = 6'd20;
  localparam logic [SLICE_W-1:0] SLICE_SCALE = 14'd10000;

  typedef enum logic [2:0] {
    OP_WRITE    = 3'd0,
    OP_PICK     = 3'd1,
    OP_WAKE     = 3'd2,
    OP_KILL     = 3'd3,
    OP_SET_NICE = 3'd4,
    OP_GET_NICE = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WR_RD,
    S_WR_WB,
    S_SCAN,
    S_EVAL,
    S_MUL,
    S_DSTART,
    S_DIV,
    S_PLACE,
    S_WAKE,
    S_UPDATE,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  slot;
    logic [30:0] task_id;
    logic [2:0]  entry_state;
    logic [5:0]  nice_value;
    logic [31:0] channel;
    logic [31:0] vruntime_in;
    logic [31:0] overflow_in;
    logic [5:0]  caller_nice;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [5:0]          chosen_slot;
    logic [SLICE_W-1:0]  slice_len;
    logic [5:0]          nice_out;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  st;
    logic [30:0] id;
    logic [5:0]  nice;
    logic [31:0] chan;
    logic [31:0] vr;
    logic [31:0] ov;
    logic        killed;
  } entry_t;

  localparam entry_t RESET_ENTRY = '{st: ST_UNUSED, id: '0, nice: RESET_NICE, chan: '0,
                                     vr: '0, ov: '0, killed: 1'b0};

  function automatic logic [WEIGHT_W-1:0] weight_of(input logic [5:0] nice);
    logic [WEIGHT_W-1:0] w;
    case (nice)
      6'd0: w = 17'd88761;   6'd1: w = 17'd71755;   6'd2: w = 17'd56483;
      6'd3: w = 17'd46273;   6'd4: w = 17'd36291;   6'd5: w = 17'd29154;
      6'd6: w = 17'd23254;   6'd7: w = 17'd18705;   6'd8: w = 17'd14949;
      6'd9: w = 17'd11916;   6'd10: w = 17'd9548;   6'd11: w = 17'd7620;
      6'd12: w = 17'd6100;   6'd13: w = 17'd4904;   6'd14: w = 17'd3906;
      6'd15: w = 17'd3121;   6'd16: w = 17'd2501;   6'd17: w = 17'd1991;
      6'd18: w = 17'd1586;   6'd19: w = 17'd1277;   6'd20: w = 17'd1024;
      6'd21: w = 17'd820;    6'd22: w = 17'd655;    6'd23: w = 17'd526;
      6'd24: w = 17'd423;    6'd25: w = 17'd335;    6'd26: w = 17'd272;
      6'd27: w = 17'd215;    6'd28: w = 17'd172;    6'd29: w = 17'd137;
      6'd30: w = 17'd110;    6'd31: w = 17'd87;     6'd32: w = 17'd70;
      6'd33: w = 17'd56;     6'd34: w = 17'd45;     6'd35: w = 17'd36;
      6'd36: w = 17'd29;     6'd37: w = 17'd23;     6'd38: w = 17'd18;
      default: w = 17'd15;
    endcase
    return w;
  endfunction

  // One scheduler tick, 1024000 divided by the weight of the nice level.
  function automatic logic [TICK_W-1:0] tick_of(input logic [5:0] nice);
    logic [TICK_W-1:0] t;
    case (nice)
      6'd0: t = 17'd11;      6'd1: t = 17'd14;      6'd2: t = 17'd18;
      6'd3: t = 17'd22;      6'd4: t = 17'd28;      6'd5: t = 17'd35;
      6'd6: t = 17'd44;      6'd7: t = 17'd54;      6'd8: t = 17'd68;
      6'd9: t = 17'd85;      6'd10: t = 17'd107;    6'd11: t = 17'd134;
      6'd12: t = 17'd167;    6'd13: t = 17'd208;    6'd14: t = 17'd262;
      6'd15: t = 17'd328;    6'd16: t = 17'd409;    6'd17: t = 17'd514;
      6'd18: t = 17'd645;    6'd19: t = 17'd801;    6'd20: t = 17'd1000;
      6'd21: t = 17'd1248;   6'd22: t = 17'd1563;   6'd23: t = 17'd1946;
      6'd24: t = 17'd2420;   6'd25: t = 17'd3056;   6'd26: t = 17'd3764;
      6'd27: t = 17'd4762;   6'd28: t = 17'd5953;   6'd29: t = 17'd7474;
      6'd30: t = 17'd9309;   6'd31: t = 17'd11770;  6'd32: t = 17'd14628;
      6'd33: t = 17'd18285;  6'd34: t = 17'd22755;  6'd35: t = 17'd28444;
      6'd36: t = 17'd35310;  6'd37: t = 17'd44521;  6'd38: t = 17'd56888;
      default: t = 17'd68266;
    endcase
    return t;
  endfunction

endpackage

// File: rtl/fstp_if.sv
// Valid/ready channel interfaces for the request and result beats.
// Depends on fstp_pkg for the beat types.
interface fstp_in_if;
  import fstp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fstp_out_if;
  import fstp_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/fair_share_task_picker_top.sv
// Fair-share task picker: slot table in one synchronous memory, scanned by a sequencer.
// Depends on fstp_pkg, fstp_if and fstp_div. One item at a time: a write goes through
// a read and a write-back of its slot; get nice, set nice and kill take one slot scan,
// pick a slot scan and the divider, wake two slot scans; rejected or unknown items
// go straight to the result.
// Synchronous reset, then a clearing pass over all NUM_SLOTS slots before input is taken.
module fair_share_task_picker_top #(
  parameter int NUM_SLOTS = fstp_pkg::NUM_SLOTS_DEF
) (
  input logic clk,
  input logic rst_n,
  fstp_in_if.sink    in_ch,
  fstp_out_if.source out_ch
);
  import fstp_pkg::*;

  localparam int AW = $clog2(NUM_SLOTS);
  localparam int CW = AW + 1;
  localparam int TW = WEIGHT_W + $clog2(NUM_SLOTS + 1);

  entry_t mem [NUM_SLOTS];
  entry_t rq_r;
  logic          re, we;
  logic [AW-1:0] ra, wa;
  entry_t        wd;

  fsm_t          state_r, state_nxt;
  logic [CW-1:0] addr_r, addr_nxt;
  logic          dv_r, dv_nxt;
  logic [AW-1:0] didx_r, didx_nxt;
  in_item_t      item_r, item_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic          min_v_r, min_v_nxt;
  logic [AW-1:0] min_idx_r, min_idx_nxt;
  entry_t        min_e_r, min_e_nxt;
  logic          hit_v_r, hit_v_nxt;
  logic [AW-1:0] hit_idx_r, hit_idx_nxt;
  entry_t        hit_e_r, hit_e_nxt;
  logic [31:0]   pl_ov_r, pl_ov_nxt;
  logic [31:0]   pl_vr_r, pl_vr_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  out_item_t     res_r, res_nxt;
  out_item_t     out_r, out_nxt;
  logic          out_v_r, out_v_nxt;

  logic              div_start, div_done;
  logic [SLICE_W-1:0] div_quo;
  logic              scan_end;
  logic [TICK_W-1:0] tick;
  logic [31:0]       vr_less;
  entry_t            e;

  fstp_div #(.NUM_W(NUM_W), .DEN_W(TW), .Q_W(SLICE_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (total_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rq_r <= mem[ra];
    end
  end

  assign scan_end = (addr_r == CW'(NUM_SLOTS));
  assign tick     = tick_of(item_r.caller_nice);
  assign vr_less  = min_e_r.vr - 32'(tick);

  always_comb begin
    state_nxt   = state_r;
    addr_nxt    = addr_r;
    dv_nxt      = 1'b0;
    didx_nxt    = didx_r;
    item_nxt    = item_r;
    total_nxt   = total_r;
    min_v_nxt   = min_v_r;
    min_idx_nxt = min_idx_r;
    min_e_nxt   = min_e_r;
    hit_v_nxt   = hit_v_r;
    hit_idx_nxt = hit_idx_r;
    hit_e_nxt   = hit_e_r;
    pl_ov_nxt   = pl_ov_r;
    pl_vr_nxt   = pl_vr_r;
    num_nxt     = num_r;
    res_nxt     = res_r;
    out_nxt     = out_r;
    out_v_nxt   = out_v_r;
    re          = 1'b0;
    ra          = addr_r[AW-1:0];
    we          = 1'b0;
    wa          = addr_r[AW-1:0];
    wd          = RESET_ENTRY;
    div_start   = 1'b0;
    e           = rq_r;
    in_ch.ready = (state_r == S_IDLE);

    if (out_v_r && out_ch.ready) begin
      out_v_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        we       = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == CW'(NUM_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          item_nxt  = in_ch.data;
          addr_nxt  = '0;
          total_nxt = '0;
          min_v_nxt = 1'b0;
          hit_v_nxt = 1'b0;
          res_nxt   = '0;
          state_nxt = S_DONE;
          case (in_ch.data.op)
            OP_WRITE: begin
              if (({26'b0, in_ch.data.slot} < 32'(NUM_SLOTS)) &&
                  (in_ch.data.entry_state <= ST_LAST)) begin
                state_nxt = S_WR_RD;
              end
            end
            OP_PICK, OP_WAKE, OP_KILL, OP_GET_NICE: state_nxt = S_SCAN;
            OP_SET_NICE: begin
              if (in_ch.data.nice_value <= MAX_NICE) begin
                state_nxt = S_SCAN;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_WR_RD: begin
        re        = 1'b1;
        ra        = AW'(item_r.slot);
        state_nxt = S_WR_WB;
      end
      S_WR_WB: begin
        we        = 1'b1;
        wa        = AW'(item_r.slot);
        wd.st     = item_r.entry_state;
        wd.id     = item_r.task_id;
        wd.nice   = (item_r.nice_value > MAX_NICE) ? MAX_NICE : item_r.nice_value;
        wd.chan   = item_r.channel;
        wd.vr     = item_r.vruntime_in;
        wd.ov     = item_r.overflow_in;
        wd.killed = (item_r.entry_state == ST_UNUSED) ? 1'b0 : rq_r.killed;
        res_nxt.found       = 1'b1;
        res_nxt.chosen_slot = item_r.slot;
        state_nxt = S_DONE;
      end
      S_SCAN, S_WAKE: begin
        if (!scan_end) begin
          re       = 1'b1;
          addr_nxt = addr_r + 1'b1;
          dv_nxt   = 1'b1;
          didx_nxt = addr_r[AW-1:0];
        end
        if (dv_r && state_r == S_SCAN) begin
          if (e.st == ST_RUNNABLE) begin
            total_nxt = total_r + TW'(weight_of(e.nice));
            if (!min_v_r || ({e.ov, e.vr} < {min_e_r.ov, min_e_r.vr})) begin
              min_v_nxt   = 1'b1;
              min_idx_nxt = didx_r;
              min_e_nxt   = e;
            end
          end
          if (e.st != ST_UNUSED && e.id == item_r.task_id && !hit_v_r) begin
            hit_v_nxt   = 1'b1;
            hit_idx_nxt = didx_r;
            hit_e_nxt   = e;
          end
        end
        if (dv_r && state_r == S_WAKE && e.st == ST_SLEEPING &&
            e.chan == item_r.channel) begin
          we    = 1'b1;
          wa    = didx_r;
          wd    = e;
          wd.st = ST_RUNNABLE;
          wd.ov = pl_ov_r;
          wd.vr = pl_vr_r;
          if (!res_r.found) begin
            res_nxt.found       = 1'b1;
            res_nxt.chosen_slot = 6'(didx_r);
          end
        end
        if (scan_end && !dv_r) begin
          state_nxt = (state_r == S_SCAN) ? S_EVAL : S_DONE;
        end
      end
      S_EVAL: begin
        state_nxt = S_DONE;
        case (item_r.op)
          OP_PICK: begin
            if (min_v_r) begin
              state_nxt = S_MUL;
            end
          end
          OP_WAKE: state_nxt = S_PLACE;
          OP_KILL: begin
            if (hit_v_r) begin
              state_nxt = S_PLACE;
            end
          end
          OP_SET_NICE: begin
            if (hit_v_r) begin
              state_nxt = S_UPDATE;
            end
          end
          OP_GET_NICE: begin
            if (hit_v_r) begin
              res_nxt.found       = 1'b1;
              res_nxt.chosen_slot = 6'(hit_idx_r);
              res_nxt.nice_out    = hit_e_r.nice;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_MUL: begin
        num_nxt   = NUM_W'(SLICE_SCALE) * NUM_W'(weight_of(min_e_r.nice));
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          we    = 1'b1;
          wa    = min_idx_r;
          wd    = min_e_r;
          wd.st = ST_RUNNING;
          res_nxt.found       = 1'b1;
          res_nxt.chosen_slot = 6'(min_idx_r);
          res_nxt.slice_len   = div_quo;
          state_nxt = S_DONE;
        end
      end
      S_PLACE: begin
        pl_ov_nxt = '0;
        pl_vr_nxt = '0;
        if (min_v_r) begin
          if (min_e_r.vr >= 32'(tick)) begin
            pl_ov_nxt = min_e_r.ov;
            pl_vr_nxt = vr_less;
          end else if (min_e_r.ov != '0) begin
            pl_ov_nxt = min_e_r.ov - 1'b1;
            pl_vr_nxt = vr_less - 1'b1;
          end
        end
        addr_nxt  = '0;
        state_nxt = (item_r.op == OP_WAKE) ? S_WAKE : S_UPDATE;
      end
      S_UPDATE: begin
        we = 1'b1;
        wa = hit_idx_r;
        wd = hit_e_r;
        if (item_r.op == OP_SET_NICE) begin
          wd.nice = item_r.nice_value;
        end else begin
          wd.killed = 1'b1;
          if (hit_e_r.st == ST_SLEEPING) begin
            wd.st = ST_RUNNABLE;
            wd.ov = pl_ov_r;
            wd.vr = pl_vr_r;
          end
        end
        res_nxt.found       = 1'b1;
        res_nxt.chosen_slot = 6'(hit_idx_r);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_v_r || out_ch.ready) begin
          out_nxt   = res_r;
          out_v_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      addr_r  <= '0;
      dv_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      dv_r    <= dv_nxt;
      out_v_r <= out_v_nxt;
    end
    didx_r    <= didx_nxt;
    item_r    <= item_nxt;
    total_r   <= total_nxt;
    min_v_r   <= min_v_nxt;
    min_idx_r <= min_idx_nxt;
    min_e_r   <= min_e_nxt;
    hit_v_r   <= hit_v_nxt;
    hit_idx_r <= hit_idx_nxt;
    hit_e_r   <= hit_e_nxt;
    pl_ov_r   <= pl_ov_nxt;
    pl_vr_r   <= pl_vr_nxt;
    num_r     <= num_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;
endmodule

// File: rtl/fstp_div.sv
// Restoring divider, one quotient bit per cycle, for the time slice.
// Depends on nothing but its parameters.
module fstp_div #(
  parameter int NUM_W = 31,
  parameter int DEN_W = 24,
  parameter int Q_W   = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] n_r, n_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    trial    = {rem_r, n_r[NUM_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      n_nxt    = num;
      q_nxt    = '0;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      n_nxt = n_r << 1;
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(trial - {1'b0, den_r});
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r   <= n_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = q_r[Q_W-1:0];
endmodule
